// ===== src/padded_plane_reader_macros.svh =====
// padded_plane_reader_macros.svh: assertion macros for the padded plane reader checker
// no dependencies; expects a clock named clk and a reset named rst in the using scope
`ifndef PADDED_PLANE_READER_MACROS_SVH
`define PADDED_PLANE_READER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PPR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("padded_plane_reader check failed");

// next-cycle implication, disabled in reset
`define PPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("padded_plane_reader check failed");

`endif

// ===== src/ppr_pkg.sv =====
// ppr_pkg: shared types and codes for the padded plane reader
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps

package ppr_pkg;

  // signed width for coordinate and plane size arithmetic
  localparam int CW = 12;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // pad modes
  localparam logic [1:0] MODE_CONST   = 2'd0;
  localparam logic [1:0] MODE_EDGE    = 2'd1;
  localparam logic [1:0] MODE_REFLECT = 2'd2;
  localparam logic [1:0] MODE_BAD     = 2'd3;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PAD_MODE   = 3'd0,
    REG_OUT_HEIGHT = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_PAD_TOP    = 3'd3,
    REG_PAD_BOTTOM = 3'd4,
    REG_PAD_LEFT   = 3'd5,
    REG_PAD_RIGHT  = 3'd6,
    REG_FILL_WORD  = 3'd7
  } reg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic map;
    logic access;
    logic respond;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_read;
  } dp_status_t;

endpackage

// ===== src/ppr_controller.sv =====
// ppr_controller: sequencer for one load or read word at a time
// depends on ppr_pkg for the command and status structs
`timescale 1ns / 1ps

module ppr_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                strobe,
  output ppr_pkg::dp_cmd_t    cmd,
  input  ppr_pkg::dp_status_t status
);
  import ppr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_ACCESS,
    S_RESP
  } state_t;

  state_t state;

  // busy also covers reset so nothing is taken then
  assign busy = (state != S_IDLE) | rst;

  // commands decoded from state
  always_comb begin
    cmd.latch   = start & ~busy;
    cmd.map     = (state == S_MAP);
    cmd.access  = (state == S_ACCESS);
    cmd.respond = (state == S_RESP);
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_RESP);
      unique case (state)
        S_IDLE: begin
          if (cmd.latch) state <= S_MAP;
        end
        S_MAP: begin
          state <= S_ACCESS;
        end
        S_ACCESS: begin
          if (status.is_read) state <= S_RESP;
          else state <= S_IDLE;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/ppr_datapath.sv =====
// ppr_datapath: config registers, coordinate mapping, plane memory and result word
// depends on ppr_pkg for types, opcodes, pad modes and register indexes
`timescale 1ns / 1ps

module ppr_datapath #(
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_IN_WIDTH  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ppr_pkg::dp_cmd_t    cmd,
  output ppr_pkg::dp_status_t status,
  input  logic                op,
  input  logic [7:0]          row,
  input  logic [7:0]          col,
  input  logic [31:0]         pixel,
  input  logic                cfg_we,
  input  ppr_pkg::reg_idx_t   cfg_index,
  input  logic [31:0]         cfg_data,
  output logic [31:0]         value,
  output logic                error
);
  import ppr_pkg::*;

  localparam int DEPTH  = MAX_IN_HEIGHT * MAX_IN_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RI_W   = $clog2(MAX_IN_HEIGHT);
  localparam int CI_W   = $clog2(MAX_IN_WIDTH);

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] idx;
  } axis_t;

  // map one output coordinate onto the input axis
  function automatic axis_t map_axis(input logic [7:0] o, input logic [5:0] p,
                                     input logic signed [CW-1:0] n, input logic [1:0] mode);
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] nm1;
    axis_t res;
    r   = $signed(CW'(o)) - $signed(CW'(p));
    nm1 = n - $signed(CW'(1));
    res.hit = 1'b1;
    res.idx = r;
    if (r < 0 || r >= n) begin
      if (mode == MODE_CONST) begin
        res.hit = 1'b0;
      end else if (mode == MODE_EDGE) begin
        res.idx = (r < 0) ? '0 : nm1;
      end else begin
        // mirror about the border pixel without repeating it
        res.idx = (r < 0) ? -r : (nm1 + nm1 - r);
      end
    end
    return res;
  endfunction

  // configuration registers
  logic [1:0]  pad_mode;
  logic [7:0]  out_height;
  logic [7:0]  out_width;
  logic [5:0]  pad_top_rows;
  logic [5:0]  pad_bottom_rows;
  logic [5:0]  pad_left_cols;
  logic [5:0]  pad_right_cols;
  logic [31:0] fill_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_mode        <= MODE_CONST;
      out_height      <= 8'd1;
      out_width       <= 8'd1;
      pad_top_rows    <= '0;
      pad_bottom_rows <= '0;
      pad_left_cols   <= '0;
      pad_right_cols  <= '0;
      fill_word       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAD_MODE:   pad_mode        <= cfg_data[1:0];
        REG_OUT_HEIGHT: out_height      <= cfg_data[7:0];
        REG_OUT_WIDTH:  out_width       <= cfg_data[7:0];
        REG_PAD_TOP:    pad_top_rows    <= cfg_data[5:0];
        REG_PAD_BOTTOM: pad_bottom_rows <= cfg_data[5:0];
        REG_PAD_LEFT:   pad_left_cols   <= cfg_data[5:0];
        REG_PAD_RIGHT:  pad_right_cols  <= cfg_data[5:0];
        REG_FILL_WORD:  fill_word       <= cfg_data;
      endcase
    end
  end

  // command word latched at accept
  logic        op_q;
  logic [7:0]  row_q;
  logic [7:0]  col_q;
  logic [31:0] pixel_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= op;
      row_q   <= row;
      col_q   <= col;
      pixel_q <= pixel;
    end
  end

  assign status.is_read = (op_q == OP_READ);

  // input plane size and error checks
  logic signed [CW-1:0] in_h;
  logic signed [CW-1:0] in_w;
  logic                 geom_err;
  logic                 refl_err;
  logic                 err;
  axis_t                map_r;
  axis_t                map_c;
  logic [CW-1:0]        sel_r;
  logic [CW-1:0]        sel_c;
  logic                 load_ok;

  always_comb begin
    in_h = $signed(CW'(out_height)) - $signed(CW'(pad_top_rows))
         - $signed(CW'(pad_bottom_rows));
    in_w = $signed(CW'(out_width)) - $signed(CW'(pad_left_cols))
         - $signed(CW'(pad_right_cols));
    geom_err = (in_h < 1) || (in_w < 1) ||
               (in_h > $signed(CW'(MAX_IN_HEIGHT))) || (in_w > $signed(CW'(MAX_IN_WIDTH)));
    refl_err = (pad_mode == MODE_REFLECT) &&
               (($signed(CW'(pad_top_rows)) >= in_h) ||
                ($signed(CW'(pad_bottom_rows)) >= in_h) ||
                ($signed(CW'(pad_left_cols)) >= in_w) ||
                ($signed(CW'(pad_right_cols)) >= in_w));
    err = (pad_mode == MODE_BAD) || (row_q >= out_height) || (col_q >= out_width) ||
          geom_err || refl_err;
    map_r = map_axis(row_q, pad_top_rows, in_h, pad_mode);
    map_c = map_axis(col_q, pad_left_cols, in_w, pad_mode);
    sel_r = (op_q == OP_READ) ? map_r.idx : CW'(row_q);
    sel_c = (op_q == OP_READ) ? map_c.idx : CW'(col_q);
    load_ok = (op_q == OP_LOAD) && (CW'(row_q) < CW'(MAX_IN_HEIGHT)) &&
              (CW'(col_q) < CW'(MAX_IN_WIDTH));
  end

  // mapped indexes and flags
  logic [RI_W-1:0] ri_q;
  logic [CI_W-1:0] ci_q;
  logic            inside_q;
  logic            err_q;
  logic            wr_q;

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      ri_q     <= sel_r[RI_W-1:0];
      ci_q     <= sel_c[CI_W-1:0];
      inside_q <= map_r.hit & map_c.hit;
      err_q    <= err;
      wr_q     <= load_ok;
    end
  end

  // plane memory, one access per item
  logic [31:0]       plane_mem [DEPTH];
  logic [31:0]       mem_q;
  logic [ADDR_W-1:0] addr;

  assign addr = ADDR_W'(ri_q) * ADDR_W'(MAX_IN_WIDTH) + ADDR_W'(ci_q);

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      if (wr_q) plane_mem[addr] <= pixel_q;
      mem_q <= plane_mem[addr];
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      value <= err_q ? '0 : (inside_q ? mem_q : fill_word);
      error <= err_q;
    end
  end

endmodule

// ===== src/padded_plane_reader.sv =====
// padded_plane_reader: a read is accepted, then map, memory access and result
// stages follow; its result strobe is registered from the result state, and no new item is taken until idle.
// a load writes the plane memory in the access stage, with no result.
// the sequencer steps map, access and result states in turn; a load skips the result state.
// synchronous reset restores config defaults and idles the sequencer; plane memory is
// not cleared. busy is high during reset and results cannot be held off.
`timescale 1ns / 1ps

module padded_plane_reader #(
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_IN_WIDTH  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [7:0]  row,
  input  logic [7:0]  col,
  input  logic [31:0] pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        strobe,
  output logic [31:0] value,
  output logic        error
);
  import ppr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // config words are taken any time outside reset
  assign cfg_ready = ~rst;

  ppr_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .cmd    (cmd),
    .status (status)
  );

  ppr_datapath #(
    .MAX_IN_HEIGHT (MAX_IN_HEIGHT),
    .MAX_IN_WIDTH  (MAX_IN_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .op        (op),
    .row       (row),
    .col       (col),
    .pixel     (pixel),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (reg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .value     (value),
    .error     (error)
  );

endmodule

// ===== src/ppr_checker.sv =====
// ppr_checker: port-level checks on the padded plane reader, bound to the top level
// depends on padded_plane_reader_macros.svh for the assertion macros
`timescale 1ns / 1ps
`include "padded_plane_reader_macros.svh"

module ppr_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [31:0] value,
  input logic        error
);

  // an accepted word keeps the block busy next cycle
  `PPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // a result only shows once the sequencer is back to idle
  `PPR_ASSERT_IMPLY(a_strobe_idle, strobe, !busy)
  // a result lasts exactly one cycle
  `PPR_ASSERT_NEXT(a_strobe_single, strobe, !strobe)
  // an error result carries a zero word
  `PPR_ASSERT_IMPLY(a_error_zero, strobe && error, value == 32'd0)

endmodule

bind padded_plane_reader ppr_checker u_ppr_checker (.*);

// ===== test/padded_plane_reader_checker.sv =====
// padded_plane_reader_checker: watches the item, register and result channels of the
// padded plane reader, predicts every read word and compares it; depends on ppr_pkg
`timescale 1ns / 1ps

module padded_plane_reader_checker #(
  parameter int PLANE_ROWS = 64,
  parameter int PLANE_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [7:0]  row,
  input  logic [7:0]  col,
  input  logic [31:0] pixel,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        strobe,
  input  logic [31:0] value,
  input  logic        error,
  output int          fail_count,
  output int          open_reads,
  output int          load_count,
  output int          result_count
);
  import ppr_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        error;
  } padded_result_t;

  // own copy of the plane and the pad registers
  logic [31:0] plane_mem [0:PLANE_ROWS*PLANE_COLS-1];
  logic [1:0]  mode_q;
  logic [7:0]  out_h_q;
  logic [7:0]  out_w_q;
  logic [5:0]  top_q;
  logic [5:0]  bottom_q;
  logic [5:0]  left_q;
  logic [5:0]  right_q;
  logic [31:0] fill_q;

  // words owed for accepted reads, oldest first
  padded_result_t awaited_words [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // map one output coordinate onto the input axis; 0 means constant padding
  function automatic bit fold_axis(input int o, input int p, input int n, output int idx);
    int r;
    r = o - p;
    idx = 0;
    if (r >= 0 && r < n) begin
      idx = r;
      return 1'b1;
    end
    if (mode_q == MODE_CONST) return 1'b0;
    if (mode_q == MODE_EDGE) begin
      idx = (r < 0) ? 0 : n - 1;
      return 1'b1;
    end
    // mirror without repeating the border pixel
    if (r < 0) r = -r;
    if (r >= n) r = 2 * (n - 1) - r;
    if (r < 0) r = 0;
    if (r >= n) r = n - 1;
    idx = r;
    return 1'b1;
  endfunction

  function automatic padded_result_t padded_word(input logic [7:0] r8, input logic [7:0] c8);
    int in_h, in_w, ri, ci;
    bit hit_r, hit_c, bad;
    padded_result_t res;
    in_h = int'(out_h_q) - int'(top_q) - int'(bottom_q);
    in_w = int'(out_w_q) - int'(left_q) - int'(right_q);
    bad = (mode_q == MODE_BAD) || (r8 >= out_h_q) || (c8 >= out_w_q) ||
          (in_h < 1) || (in_w < 1) || (in_h > PLANE_ROWS) || (in_w > PLANE_COLS);
    // reflect needs every pad smaller than the input size
    if (mode_q == MODE_REFLECT &&
        (int'(top_q) >= in_h || int'(bottom_q) >= in_h ||
         int'(left_q) >= in_w || int'(right_q) >= in_w))
      bad = 1'b1;
    res.value = '0;
    res.error = bad;
    if (!bad) begin
      hit_r = fold_axis(int'(r8), int'(top_q), in_h, ri);
      hit_c = fold_axis(int'(c8), int'(left_q), in_w, ci);
      res.value = (hit_r && hit_c) ? plane_mem[ri * PLANE_COLS + ci] : fill_q;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    padded_result_t want;
    if (rst) begin
      mode_q = MODE_CONST;
      out_h_q = 8'd1;
      out_w_q = 8'd1;
      top_q = '0;
      bottom_q = '0;
      left_q = '0;
      right_q = '0;
      fill_q = '0;
      awaited_words.delete();
      fail_count = 0;
      load_count = 0;
      result_count = 0;
    end else begin
      // result words, compared in order
      if ($isunknown(strobe)) begin
        report_mismatch("result strobe is unknown");
      end else if (strobe) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("result word with no read waiting: value %h error %b",
                                    value, error));
        end else begin
          want = awaited_words.pop_front();
          result_count++;
          if (value !== want.value)
            report_mismatch($sformatf("read word value %h, expected %h", value, want.value));
          if (error !== want.error)
            report_mismatch($sformatf("read word error %b, expected %b", error, want.error));
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAD_MODE:   mode_q = cfg_data[1:0];
          REG_OUT_HEIGHT: out_h_q = cfg_data[7:0];
          REG_OUT_WIDTH:  out_w_q = cfg_data[7:0];
          REG_PAD_TOP:    top_q = cfg_data[5:0];
          REG_PAD_BOTTOM: bottom_q = cfg_data[5:0];
          REG_PAD_LEFT:   left_q = cfg_data[5:0];
          REG_PAD_RIGHT:  right_q = cfg_data[5:0];
          REG_FILL_WORD:  fill_q = cfg_data;
        endcase
      end
      // accepted items
      if (start && !busy) begin
        if (op == OP_LOAD) begin
          load_count++;
          if (row < PLANE_ROWS && col < PLANE_COLS)
            plane_mem[row * PLANE_COLS + col] = pixel;
        end else begin
          awaited_words.push_back(padded_word(row, col));
        end
      end
    end
    open_reads = awaited_words.size();
  end

endmodule

// ===== test/padded_plane_reader_test.sv =====
// padded_plane_reader_test: drives loads, reads and pad settings into the padded plane
// reader and gives the verdict; depends on ppr_pkg and padded_plane_reader_checker
`timescale 1ns / 1ps

module padded_plane_reader_test;
  import ppr_pkg::*;

  localparam int PLANE_ROWS   = 64;
  localparam int PLANE_COLS   = 64;
  localparam int RANDOM_ITEMS = 1800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        op = OP_LOAD;
  logic [7:0]  row = '0;
  logic [7:0]  col = '0;
  logic [31:0] pixel = '0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        cfg_ready;
  logic        strobe;
  logic [31:0] value;
  logic        error;

  int fail_count, open_reads, load_count, result_count;

  // current pad setting as seen by the stimulus
  int         idle_pct = 33;
  int         setting_count = 0;
  int         cur_out_h = 1;
  int         cur_out_w = 1;
  int         cur_in_h = 1;
  int         cur_in_w = 1;
  bit         plane_written [0:PLANE_ROWS*PLANE_COLS-1];

  padded_plane_reader #(
    .MAX_IN_HEIGHT(PLANE_ROWS),
    .MAX_IN_WIDTH (PLANE_COLS)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .row(row), .col(col), .pixel(pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .value(value), .error(error)
  );

  padded_plane_reader_checker #(
    .PLANE_ROWS(PLANE_ROWS),
    .PLANE_COLS(PLANE_COLS)
  ) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .row(row), .col(col), .pixel(pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .value(value), .error(error),
    .fail_count(fail_count), .open_reads(open_reads),
    .load_count(load_count), .result_count(result_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d reads still waiting", open_reads);
    $display("** padded_plane_reader: FAILED **");
    $finish;
  end

  function automatic bit plane_fits(input int ih, input int iw);
    return ih >= 1 && ih <= PLANE_ROWS && iw >= 1 && iw <= PLANE_COLS;
  endfunction

  // cells of the input region that a fill would still have to load
  function automatic int unwritten_cells(input int ih, input int iw);
    int r, c, n;
    n = 0;
    if (!plane_fits(ih, iw)) return 0;
    for (r = 0; r < ih; r++)
      for (c = 0; c < iw; c++)
        if (!plane_written[r * PLANE_COLS + c]) n++;
    return n;
  endfunction

  // register data, with junk above the register width when asked
  function automatic logic [31:0] noisy(input logic [31:0] v, input logic [31:0] mask,
                                        input bit junk);
    logic [31:0] noise;
    noise = junk ? $urandom() : 32'd0;
    return (noise & ~mask) | (v & mask);
  endfunction

  // one item word, held until taken; called at a falling edge
  task automatic send_item(input logic o, input logic [7:0] r, input logic [7:0] c,
                           input logic [31:0] px);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    op <= o;
    row <= r;
    col <= c;
    pixel <= px;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (o == OP_LOAD && r < PLANE_ROWS && c < PLANE_COLS)
      plane_written[r * PLANE_COLS + c] = 1'b1;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    while ($urandom_range(99) < idle_pct) begin
      cfg_valid <= 1'b0;
      @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // stop sending and let the block settle
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (open_reads != 0);
    repeat (4) @(negedge clk);
  endtask

  // new pad setting, then, unless the mode is bad or the plane does not fit, load the still unwritten input region
  task automatic set_geometry(input logic [1:0] mode, input int oh, input int ow,
                              input int pt, input int pb, input int pl, input int pr,
                              input logic [31:0] fill, input bit junk);
    int r, c;
    drain();
    write_reg(REG_PAD_MODE,   noisy(32'(mode), 32'h3, junk));
    write_reg(REG_OUT_HEIGHT, noisy(oh, 32'hff, junk));
    write_reg(REG_OUT_WIDTH,  noisy(ow, 32'hff, junk));
    write_reg(REG_PAD_TOP,    noisy(pt, 32'h3f, junk));
    write_reg(REG_PAD_BOTTOM, noisy(pb, 32'h3f, junk));
    write_reg(REG_PAD_LEFT,   noisy(pl, 32'h3f, junk));
    write_reg(REG_PAD_RIGHT,  noisy(pr, 32'h3f, junk));
    write_reg(REG_FILL_WORD,  fill);
    cfg_valid <= 1'b0;
    cur_out_h = oh;
    cur_out_w = ow;
    cur_in_h = oh - pt - pb;
    cur_in_w = ow - pl - pr;
    setting_count++;
    if (mode != MODE_BAD && plane_fits(cur_in_h, cur_in_w))
      for (r = 0; r < cur_in_h; r++)
        for (c = 0; c < cur_in_w; c++)
          if (!plane_written[r * PLANE_COLS + c])
            send_item(OP_LOAD, 8'(r), 8'(c), $urandom());
  endtask

  // mostly reads inside the padded plane, some loads and some stray reads
  task automatic run_items(input int n, input bit pause_mid);
    int k, pick;
    logic [7:0] r, c;
    for (k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) begin
        start <= 1'b0;
        do @(negedge clk); while (open_reads != 0);
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        if (plane_fits(cur_in_h, cur_in_w) && $urandom_range(3) != 0) begin
          r = 8'($urandom_range(0, cur_in_h - 1));
          c = 8'($urandom_range(0, cur_in_w - 1));
        end else begin
          r = 8'($urandom_range(0, 255));
          c = 8'($urandom_range(0, 255));
        end
        send_item(OP_LOAD, r, c, $urandom());
      end else if (pick < 85) begin
        r = 8'($urandom_range(0, cur_out_h - 1));
        c = 8'($urandom_range(0, cur_out_w - 1));
        send_item(OP_READ, r, c, $urandom());
      end else begin
        send_item(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  $urandom());
      end
    end
  endtask

  initial begin : stimulus
    int random_items, rnd_setting, tries, pick;
    int ih, iw, oh, ow, pt, pb, pl, pr;
    logic [1:0] mode;
    bit junk;
    random_items = 0;
    rnd_setting = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: a 1x1 plane with no pads
    send_item(OP_LOAD, 8'd0, 8'd0, 32'hffff_ffff);
    send_item(OP_READ, 8'd0, 8'd0, 32'h0);
    send_item(OP_READ, 8'd0, 8'd1, 32'hffff_ffff);
    send_item(OP_READ, 8'd1, 8'd0, 32'h0);
    send_item(OP_READ, 8'd255, 8'd255, 32'h0);
    // loads past the plane are dropped and must not alias onto real cells
    send_item(OP_LOAD, 8'd64, 8'd0, 32'h1234_5678);
    send_item(OP_LOAD, 8'd0, 8'd64, 32'h8765_4321);
    send_item(OP_LOAD, 8'd255, 8'd255, 32'hdead_beef);
    send_item(OP_LOAD, 8'd63, 8'd63, 32'h0);
    send_item(OP_READ, 8'd0, 8'd0, 32'h0);

    // fixed settings: every mode, largest pads, bad geometry
    set_geometry(MODE_CONST, 6, 7, 1, 2, 2, 1, 32'hffff_ffff, 1'b0);
    run_items(12, 1'b0);
    set_geometry(MODE_EDGE, 9, 8, 3, 2, 1, 3, 32'h0, 1'b0);
    run_items(12, 1'b0);
    set_geometry(MODE_REFLECT, 10, 13, 3, 3, 4, 4, 32'ha5a5_5a5a, 1'b0);
    run_items(20, 1'b0);
    set_geometry(MODE_REFLECT, 6, 5, 3, 0, 1, 1, 32'h5a5a_a5a5, 1'b0);
    run_items(8, 1'b0);
    set_geometry(MODE_BAD, 6, 7, 1, 2, 2, 1, 32'hffff_ffff, 1'b0);
    run_items(8, 1'b0);
    set_geometry(MODE_CONST, 1, 4, 63, 0, 2, 2, 32'h1, 1'b0);
    run_items(8, 1'b0);
    set_geometry(MODE_EDGE, 190, 190, 0, 0, 0, 0, 32'h0, 1'b0);
    run_items(8, 1'b0);
    set_geometry(MODE_REFLECT, 190, 4, 63, 63, 1, 1, 32'hffff_0000, 1'b0);
    run_items(30, 1'b0);
    set_geometry(MODE_EDGE, 4, 190, 1, 1, 63, 63, 32'h0000_ffff, 1'b0);
    run_items(30, 1'b0);
    set_geometry(MODE_CONST, 190, 128, 63, 63, 63, 63, 32'h8000_0001, 1'b0);
    run_items(20, 1'b0);
    set_geometry(MODE_REFLECT, 1, 1, 0, 0, 0, 0, 32'h0, 1'b0);
    run_items(8, 1'b0);

    // random settings, mostly small planes
    while (random_items < RANDOM_ITEMS) begin
      rnd_setting++;
      idle_pct = (rnd_setting >= 3 && rnd_setting <= 5) ? 0 : 33;
      if ($urandom_range(99) < 15) begin
        // any register value, junk in the unused data bits
        junk = 1'b1;
        tries = 0;
        do begin
          mode = 2'($urandom_range(0, 3));
          oh = $urandom_range(1, 190);
          ow = $urandom_range(1, 190);
          pt = $urandom_range(0, 63);
          pb = $urandom_range(0, 63);
          pl = $urandom_range(0, 63);
          pr = $urandom_range(0, 63);
          tries++;
        end while (tries < 20 && unwritten_cells(oh - pt - pb, ow - pl - pr) > 300);
        if (unwritten_cells(oh - pt - pb, ow - pl - pr) > 300) mode = MODE_BAD;
      end else begin
        junk = 1'b0;
        pick = $urandom_range(99);
        mode = (pick < 4) ? MODE_BAD : 2'($urandom_range(0, 2));
        ih = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
        iw = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
        if (mode == MODE_REFLECT) begin
          pt = $urandom_range(0, ih - 1);
          pb = $urandom_range(0, ih - 1);
          pl = $urandom_range(0, iw - 1);
          pr = $urandom_range(0, iw - 1);
        end else begin
          pt = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
          pb = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
          pl = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
          pr = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
        end
        oh = ih + pt + pb;
        ow = iw + pl + pr;
      end
      set_geometry(mode, oh, ow, pt, pb, pl, pr, $urandom(), junk);
      pick = $urandom_range(30, 70);
      run_items(pick, rnd_setting == 2);
      random_items += pick;
    end

    idle_pct = 33;
    drain();
    repeat (8) @(negedge clk);

    $display("covered %0d pad settings, %0d pixel loads and %0d checked read words,",
             setting_count, load_count, result_count);
    $display("with random gaps, a gap-free stretch and a pause until all reads returned");
    if (open_reads != 0) $display("%0d reads never returned a word", open_reads);
    if (fail_count == 0 && open_reads == 0)
      $display("** padded_plane_reader: PASSED **");
    else
      $display("** padded_plane_reader: FAILED **");
    $finish;
  end

endmodule
